// File: rtl/core/svwb_pkg.sv
// shared types, constants and helper functions for the session vwap core
// no dependencies
`timescale 1ns / 1ps

package svwb_pkg;

	localparam logic [1:0] FAULT_NONE  = 2'd0;
	localparam logic [1:0] FAULT_INPUT = 2'd1;
	localparam logic [1:0] FAULT_TIME  = 2'd2;

	localparam logic [7:0] CFG_BAND_WIDTH_1 = 8'd0;
	localparam logic [7:0] CFG_BAND_WIDTH_2 = 8'd1;

	localparam logic [14:0] BAND_MAX       = 15'd25600;
	localparam logic [14:0] BAND_1_RESET   = 15'd256;
	localparam logic [14:0] BAND_2_RESET   = 15'd512;
	localparam logic [26:0] DATE_MAX       = 27'd99991231;
	localparam logic [30:0] DIV100_MAGIC   = 31'd1374389535;
	localparam int          DIV100_SHIFT   = 37;
	localparam int          DIV_STEPS      = 40;
	localparam logic [47:0] ROOT_FIRST_BIT = 48'h4000_0000_0000;

	typedef struct packed {
		logic [15:0] price_open;
		logic [15:0] price_high;
		logic [15:0] price_low;
		logic [15:0] price_close;
		logic [15:0] bar_volume;
		logic [47:0] close_time;
		logic [26:0] trade_date;
	} bar_t;

	typedef struct packed {
		logic [1:0]         fault;
		logic               replaced;
		logic               bands_valid;
		logic [23:0]        vwap_value;
		logic signed [31:0] upper_band_1;
		logic signed [31:0] lower_band_1;
		logic signed [31:0] upper_band_2;
		logic signed [31:0] lower_band_2;
		logic [47:0]        result_time;
	} result_t;

	typedef struct packed {
		logic [1:0]  fault;
		logic        replaced;
		logic [47:0] close_time;
		logic [63:0] spv;
		logic [47:0] sv;
		logic [63:0] ssq;
	} job_t;

	function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
		logic [4:0] d;
		case (m)
			4'd2: d = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11: d = 5'd30;
			default: d = 5'd31;
		endcase
		return d;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
		logic signed [31:0] r;
		if (v > 36'sd2147483647)
			r = 32'sh7FFF_FFFF;
		else if (v < -36'sd2147483648)
			r = 32'sh8000_0000;
		else
			r = v[31:0];
		return r;
	endfunction

endpackage

// File: rtl/core/session_vwap_with_deviation_bands_core.sv
// channel  | direction | handshake           | payload
// in       | input     | in_valid/in_ready   | in_data (bar_t)
// out      | output    | out_valid/out_ready | out_data (result_t)
// cfg      | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
// the front splits the date into digits by repeated divide-by-100 steps, then forms the products in F_MUL1 and F_MUL2
// the back runs the two-bit-a-step dividers for each bar, then the square root
// sustained rate is set by the back; the two-entry queue lets the front run ahead
// asynchronous active-low reset clears control state and the session sums
// depends on svwb_pkg, svwb_front, svwb_fifo, svwb_back
`timescale 1ns / 1ps

module session_vwap_with_deviation_bands_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  svwb_pkg::bar_t    in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output svwb_pkg::result_t out_data,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [7:0]        cfg_index,
	input  logic [14:0]       cfg_data
);

	logic [14:0] bw1_q, bw2_q, cfg_sat;
	logic        fj_valid, fj_ready, bj_valid, bj_ready;
	svwb_pkg::job_t fj, bj;

	assign cfg_ready = 1'b1;
	assign cfg_sat   = (cfg_data > svwb_pkg::BAND_MAX) ? svwb_pkg::BAND_MAX : cfg_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bw1_q <= svwb_pkg::BAND_1_RESET;
			bw2_q <= svwb_pkg::BAND_2_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				svwb_pkg::CFG_BAND_WIDTH_1: bw1_q <= cfg_sat;
				svwb_pkg::CFG_BAND_WIDTH_2: bw2_q <= cfg_sat;
				default: ;
			endcase
		end
	end

	svwb_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.job_valid (fj_valid),
		.job_ready (fj_ready),
		.job       (fj)
	);

	svwb_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fj_valid),
		.push_ready (fj_ready),
		.push_data  (fj),
		.pop_valid  (bj_valid),
		.pop_ready  (bj_ready),
		.pop_data   (bj)
	);

	svwb_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.job_valid    (bj_valid),
		.job_ready    (bj_ready),
		.job          (bj),
		.band_width_1 (bw1_q),
		.band_width_2 (bw2_q),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_data     (out_data)
	);

endmodule

// File: rtl/core/svwb_front.sv
// front part: accepts bars, checks them, keeps the session sums and queues a job
// depends on svwb_pkg
`timescale 1ns / 1ps

module svwb_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  svwb_pkg::bar_t    in_data,
	output logic              job_valid,
	input  logic              job_ready,
	output svwb_pkg::job_t    job
);

	typedef enum logic [7:0] {
		F_IDLE  = 8'b0000_0001,
		F_DMUL  = 8'b0000_0010,
		F_DREM  = 8'b0000_0100,
		F_CHECK = 8'b0000_1000,
		F_MUL1  = 8'b0001_0000,
		F_MUL2  = 8'b0010_0000,
		F_ACC   = 8'b0100_0000,
		F_PUSH  = 8'b1000_0000
	} fstate_t;

	fstate_t state_q;

	svwb_pkg::bar_t bar_q;
	logic [26:0] x_q;
	logic [20:0] q_q;
	logic [1:0]  step_q;
	logic [6:0]  dd_q, mo_q, ymod_q;
	logic [13:0] y_q;
	logic [1:0]  ycent_q;
	logic [17:0] tp3_q;
	logic [35:0] tp2_q;
	logic [33:0] pv_q;
	logic [51:0] pv2_q;
	logic [1:0]  fault_q;
	logic        replaced_q;

	logic [63:0] spv_q, ssq_q, sspv_q, sssq_q;
	logic [47:0] sv_q, ssv_q, latest_q;
	logic [26:0] date_q, sdate_q;
	logic        seen_q;

	logic [57:0] prod;
	logic [27:0] q100;
	logic [6:0]  rem;
	logic        leap, date_good, price_bad, replace;
	logic [1:0]  fault_c;
	logic [26:0] base_date;
	logic        clr;
	logic [64:0] sum_spv, sum_ssq;
	logic [48:0] sum_sv;

	assign prod = 58'(x_q) * 58'(svwb_pkg::DIV100_MAGIC);
	assign q100 = (28'(q_q) << 6) + (28'(q_q) << 5) + (28'(q_q) << 2);
	assign rem  = 7'(28'(x_q) - q100);

	assign leap = (y_q[1:0] == 2'd0) && ((ymod_q != 7'd0) || (ycent_q == 2'd0));
	assign date_good = (bar_q.trade_date != 27'd0) && (bar_q.trade_date <= svwb_pkg::DATE_MAX)
		&& (y_q != 14'd0) && (mo_q >= 7'd1) && (mo_q <= 7'd12) && (dd_q >= 7'd1)
		&& (dd_q <= 7'(svwb_pkg::month_days(mo_q[3:0], leap)));
	assign price_bad = (bar_q.price_open == 16'd0) || (bar_q.price_high == 16'd0)
		|| (bar_q.price_low == 16'd0) || (bar_q.price_close == 16'd0)
		|| (bar_q.price_high < bar_q.price_open) || (bar_q.price_high < bar_q.price_close)
		|| (bar_q.price_low > bar_q.price_open) || (bar_q.price_low > bar_q.price_close)
		|| (bar_q.price_high < bar_q.price_low) || (bar_q.close_time == 48'd0);

	always_comb begin
		if (price_bad || !date_good)
			fault_c = svwb_pkg::FAULT_INPUT;
		else if (seen_q && (bar_q.close_time < latest_q))
			fault_c = svwb_pkg::FAULT_TIME;
		else if ((date_q != 27'd0) && (bar_q.trade_date < date_q))
			fault_c = svwb_pkg::FAULT_INPUT;
		else
			fault_c = svwb_pkg::FAULT_NONE;
	end

	assign replace   = seen_q && (bar_q.close_time == latest_q);
	assign base_date = replace ? sdate_q : date_q;
	assign clr       = (base_date != 27'd0) && (bar_q.trade_date != base_date);

	assign sum_spv = {1'b0, spv_q} + 65'(pv_q);
	assign sum_ssq = {1'b0, ssq_q} + 65'(pv2_q);
	assign sum_sv  = {1'b0, sv_q} + 49'(bar_q.bar_volume);

	assign in_ready  = (state_q == F_IDLE);
	assign job_valid = (state_q == F_PUSH);
	assign job.fault      = fault_q;
	assign job.replaced   = replaced_q;
	assign job.close_time = bar_q.close_time;
	assign job.spv        = spv_q;
	assign job.sv         = sv_q;
	assign job.ssq        = ssq_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= F_IDLE;
			step_q   <= 2'd0;
			spv_q    <= '0;
			sv_q     <= '0;
			ssq_q    <= '0;
			date_q   <= '0;
			sspv_q   <= '0;
			ssv_q    <= '0;
			sssq_q   <= '0;
			sdate_q  <= '0;
			latest_q <= '0;
			seen_q   <= 1'b0;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					step_q <= 2'd0;
					if (in_valid)
						state_q <= F_DMUL;
				end
				F_DMUL: state_q <= F_DREM;
				F_DREM: begin
					step_q <= step_q + 2'd1;
					state_q <= (step_q == 2'd2) ? F_CHECK : F_DMUL;
				end
				F_CHECK: begin
					if (fault_c != svwb_pkg::FAULT_NONE) begin
						state_q <= F_PUSH;
					end else begin
						state_q <= F_MUL1;
						if (!replace) begin
							sspv_q   <= spv_q;
							ssv_q    <= sv_q;
							sssq_q   <= ssq_q;
							sdate_q  <= date_q;
							latest_q <= bar_q.close_time;
							seen_q   <= 1'b1;
						end
						spv_q  <= clr ? 64'd0 : (replace ? sspv_q : spv_q);
						sv_q   <= clr ? 48'd0 : (replace ? ssv_q : sv_q);
						ssq_q  <= clr ? 64'd0 : (replace ? sssq_q : ssq_q);
						date_q <= bar_q.trade_date;
					end
				end
				F_MUL1: state_q <= F_MUL2;
				F_MUL2: state_q <= F_ACC;
				F_ACC: begin
					spv_q <= sum_spv[64] ? '1 : sum_spv[63:0];
					ssq_q <= sum_ssq[64] ? '1 : sum_ssq[63:0];
					sv_q  <= sum_sv[48] ? '1 : sum_sv[47:0];
					state_q <= F_PUSH;
				end
				F_PUSH: begin
					if (job_ready)
						state_q <= F_IDLE;
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			F_IDLE: begin
				bar_q <= in_data;
				x_q   <= in_data.trade_date;
			end
			F_DMUL: q_q <= prod[57:svwb_pkg::DIV100_SHIFT];
			F_DREM: begin
				case (step_q)
					2'd0: begin
						dd_q <= rem;
						x_q  <= 27'(q_q);
					end
					2'd1: begin
						mo_q <= rem;
						y_q  <= 14'(q_q);
						x_q  <= 27'(q_q);
					end
					default: begin
						ymod_q  <= rem;
						ycent_q <= q_q[1:0];
					end
				endcase
			end
			F_CHECK: begin
				fault_q    <= fault_c;
				replaced_q <= (fault_c == svwb_pkg::FAULT_NONE) && replace;
				tp3_q <= 18'(bar_q.price_high) + 18'(bar_q.price_low) + 18'(bar_q.price_close);
			end
			F_MUL1: begin
				tp2_q <= 36'(tp3_q) * 36'(tp3_q);
				pv_q  <= 34'(tp3_q) * 34'(bar_q.bar_volume);
			end
			F_MUL2: pv2_q <= 52'(tp2_q) * 52'(bar_q.bar_volume);
			default: ;
		endcase
	end

endmodule

// File: rtl/core/svwb_fifo.sv
// two-entry job queue between the front and back parts
// depends on svwb_pkg
`timescale 1ns / 1ps

module svwb_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  svwb_pkg::job_t push_data,
	output logic           pop_valid,
	input  logic           pop_ready,
	output svwb_pkg::job_t pop_data
);

	svwb_pkg::job_t mem_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;
	logic       push, pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (pop)
				rd_ptr_q <= ~rd_ptr_q;
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

endmodule

// File: rtl/core/svwb_back.sv
// back part: divides the sums, takes the square root and forms the bands
// depends on svwb_pkg
`timescale 1ns / 1ps

module svwb_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              job_valid,
	output logic              job_ready,
	input  svwb_pkg::job_t    job,
	input  logic [14:0]       band_width_1,
	input  logic [14:0]       band_width_2,
	output logic              out_valid,
	input  logic              out_ready,
	output svwb_pkg::result_t out_data
);

	typedef enum logic [7:0] {
		B_IDLE = 8'b0000_0001,
		B_PREP = 8'b0000_0010,
		B_DIV  = 8'b0000_0100,
		B_SQ   = 8'b0000_1000,
		B_VAR  = 8'b0001_0000,
		B_ROOT = 8'b0010_0000,
		B_OFF  = 8'b0100_0000,
		B_BAND = 8'b1000_0000
	} bstate_t;

	bstate_t state_q;
	svwb_pkg::job_t job_q;
	logic        zero_q;
	logic [5:0]  cnt_q;
	logic [51:0] d3_q, d9_q, ra_q, rb_q;
	logic [79:0] na_q, nb_q;
	logic [23:0] qa_q, vwap_q;
	logic [47:0] qb_q, msq_q, rx_q, res_q, bit_q;
	logic        sata_q, satb_q;
	logic [32:0] off1_q, off2_q;
	logic        out_valid_q;
	svwb_pkg::result_t out_q;

	logic [51:0] ra, rb;
	logic [52:0] rsa, rsb;
	logic [79:0] na, nb;
	logic [23:0] qa;
	logic [47:0] qb;
	logic        sa, sb;
	logic [47:0] sq, trial;
	logic [39:0] prod1, prod2;
	logic signed [35:0] vws, up1, lo1, up2, lo2;
	logic        load;
	svwb_pkg::result_t res_c;

	always_comb begin
		na = na_q;
		nb = nb_q;
		ra = ra_q;
		rb = rb_q;
		qa = qa_q;
		qb = qb_q;
		sa = sata_q;
		sb = satb_q;
		rsa = '0;
		rsb = '0;
		for (int i = 0; i < 2; i++) begin
			rsa = {ra, na[79]};
			rsb = {rb, nb[79]};
			na = na << 1;
			nb = nb << 1;
			sa = sa | qa[23];
			sb = sb | qb[47];
			if (rsa >= {1'b0, d3_q}) begin
				ra = 52'(rsa - {1'b0, d3_q});
				qa = {qa[22:0], 1'b1};
			end else begin
				ra = rsa[51:0];
				qa = {qa[22:0], 1'b0};
			end
			if (rsb >= {1'b0, d9_q}) begin
				rb = 52'(rsb - {1'b0, d9_q});
				qb = {qb[46:0], 1'b1};
			end else begin
				rb = rsb[51:0];
				qb = {qb[46:0], 1'b0};
			end
		end
	end

	assign sq    = 48'(vwap_q) * 48'(vwap_q);
	assign trial = res_q + bit_q;
	assign prod1 = 40'(band_width_1) * 40'(res_q[24:0]);
	assign prod2 = 40'(band_width_2) * 40'(res_q[24:0]);

	assign vws = $signed({12'd0, vwap_q});
	assign up1 = vws + $signed({3'd0, off1_q});
	assign lo1 = vws - $signed({3'd0, off1_q});
	assign up2 = vws + $signed({3'd0, off2_q});
	assign lo2 = vws - $signed({3'd0, off2_q});

	always_comb begin
		res_c.fault       = job_q.fault;
		res_c.replaced    = job_q.replaced;
		res_c.result_time = job_q.close_time;
		if (zero_q) begin
			res_c.bands_valid  = 1'b0;
			res_c.vwap_value   = '0;
			res_c.upper_band_1 = '0;
			res_c.lower_band_1 = '0;
			res_c.upper_band_2 = '0;
			res_c.lower_band_2 = '0;
		end else begin
			res_c.bands_valid  = 1'b1;
			res_c.vwap_value   = vwap_q;
			res_c.upper_band_1 = svwb_pkg::sat32(up1);
			res_c.lower_band_1 = svwb_pkg::sat32(lo1);
			res_c.upper_band_2 = svwb_pkg::sat32(up2);
			res_c.lower_band_2 = svwb_pkg::sat32(lo2);
		end
	end

	assign job_ready = (state_q == B_IDLE);
	assign load      = (state_q == B_BAND) && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				B_IDLE: begin
					if (job_valid)
						state_q <= ((job.fault != svwb_pkg::FAULT_NONE) || (job.sv == 48'd0))
							? B_BAND : B_PREP;
				end
				B_PREP: begin
					cnt_q   <= '0;
					state_q <= B_DIV;
				end
				B_DIV: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'(svwb_pkg::DIV_STEPS - 1))
						state_q <= B_SQ;
				end
				B_SQ:   state_q <= B_VAR;
				B_VAR:  state_q <= B_ROOT;
				B_ROOT: begin
					if (bit_q[0])
						state_q <= B_OFF;
				end
				B_OFF: state_q <= B_BAND;
				B_BAND: begin
					if (load)
						state_q <= B_IDLE;
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			out_q <= res_c;
		unique case (state_q)
			B_IDLE: begin
				job_q  <= job;
				zero_q <= (job.fault != svwb_pkg::FAULT_NONE) || (job.sv == 48'd0);
			end
			B_PREP: begin
				d3_q   <= 52'(job_q.sv) + (52'(job_q.sv) << 1);
				d9_q   <= 52'(job_q.sv) + (52'(job_q.sv) << 3);
				na_q   <= {8'd0, job_q.spv, 8'd0};
				nb_q   <= {job_q.ssq, 16'd0};
				ra_q   <= '0;
				rb_q   <= '0;
				qa_q   <= '0;
				qb_q   <= '0;
				sata_q <= 1'b0;
				satb_q <= 1'b0;
			end
			B_DIV: begin
				na_q   <= na;
				nb_q   <= nb;
				ra_q   <= ra;
				rb_q   <= rb;
				qa_q   <= qa;
				qb_q   <= qb;
				sata_q <= sa;
				satb_q <= sb;
			end
			B_SQ: begin
				vwap_q <= sata_q ? '1 : qa_q;
				msq_q  <= satb_q ? '1 : qb_q;
			end
			B_VAR: begin
				rx_q  <= (msq_q > sq) ? (msq_q - sq) : 48'd0;
				res_q <= '0;
				bit_q <= svwb_pkg::ROOT_FIRST_BIT;
			end
			B_ROOT: begin
				if (rx_q >= trial) begin
					rx_q  <= rx_q - trial;
					res_q <= (res_q >> 1) + bit_q;
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			B_OFF: begin
				off1_q <= 33'((41'(prod1) + 41'd128) >> 8);
				off2_q <= 33'((41'(prod2) + 41'd128) >> 8);
			end
			default: ;
		endcase
	end

`ifndef SYNTH
	a_fault_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (out_q.fault != svwb_pkg::FAULT_NONE) |->
			!out_q.bands_valid && !out_q.replaced)
		else $error("faulted result carries values");
	a_band_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.bands_valid |->
			(out_q.lower_band_1 <= out_q.upper_band_1)
			&& (out_q.lower_band_2 <= out_q.upper_band_2))
		else $error("band order broken");
	a_hold_full: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_BAND) && out_valid_q && !out_ready |=> (state_q == B_BAND))
		else $error("result dropped while output full");
`endif

endmodule
